// ===== rtl/core/pbts_pkg.sv =====
`timescale 1ns / 1ps
package pbts_pkg;
	typedef enum logic [3:0] {
		OP_TICK = 4'd0, OP_INT_ENTER = 4'd1, OP_INT_EXIT = 4'd2, OP_LOCK = 4'd3,
		OP_UNLOCK = 4'd4, OP_SCHEDULE = 4'd5, OP_START = 4'd6, OP_READY = 4'd7,
		OP_UNREADY = 4'd8, OP_DELAY = 4'd9, OP_SUSPEND = 4'd10, OP_RESUME = 4'd11
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_SWEEP, ST_DECIDE, ST_OUT
	} state_t;

	localparam int OP_BITS = 4;
	localparam int PRIO_BITS = 6;
	localparam int TICK_IN_BITS = 16;
	localparam int DEPTH_BITS = 8;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = 8'd255;

	typedef struct packed {
		logic exec;
		logic sweep_start;
		logic sweep_step;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic sweep_needed;
		logic sweep_last;
		logic decide_needed;
	} stat_t;
endpackage

// ===== rtl/core/pbts_ctrl.sv =====
`timescale 1ns / 1ps
module pbts_ctrl import pbts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (stat.sweep_needed) state_d = ST_SWEEP;
				else if (stat.decide_needed) state_d = ST_DECIDE;
				else state_d = ST_OUT;
			end
			ST_SWEEP: if (stat.sweep_last) state_d = ST_OUT;
			ST_DECIDE: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.sweep_start = stat.sweep_needed;
			end
			ST_SWEEP: cmd.sweep_step = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/pbts_dp.sv =====
`timescale 1ns / 1ps
module pbts_dp import pbts_pkg::*; #(
	parameter int TASK_COUNT = 64,
	parameter int WORD_BITS = 32,
	parameter int DELAY_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_take,
	input  logic [OP_BITS-1:0]      operation,
	input  logic [PRIO_BITS-1:0]    task_prio,
	input  logic [TICK_IN_BITS-1:0] delay_ticks,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	output logic [PRIO_BITS-1:0]    next_prio,
	output logic                    decided,
	output logic                    switch_request,
	output logic                    from_interrupt,
	output logic [DEPTH_BITS-1:0]   int_depth_now,
	output logic [DEPTH_BITS-1:0]   lock_depth_now,
	output logic                    running_now,
	output logic                    none_ready
);
	localparam int IDX_BITS = $clog2(TASK_COUNT);
	localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};
	localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TASK_COUNT - 1);

	logic [OP_BITS-1:0] op_q;
	logic [IDX_BITS-1:0] prio_q;
	logic [TICK_IN_BITS-1:0] ticks_q;
	logic [TASK_COUNT-1:0] ready_q, blocked_q, susp_q;
	logic [DELAY_BITS-1:0] dcount_q [TASK_COUNT];
	logic [DEPTH_BITS-1:0] int_q, lock_q;
	logic running_q;
	logic [PRIO_BITS-1:0] cur_q;
	logic [WORD_BITS-1:0] tick_q;
	logic [IDX_BITS-1:0] idx_q;
	logic decide_q, from_int_q, sw_q, none_q;

	logic [DELAY_BITS-1:0] ticks_sat;
	logic [DEPTH_BITS-1:0] int_dec;
	logic decide_need;
	logic [IDX_BITS-1:0] top_idx;
	logic top_any;
	logic [DELAY_BITS-1:0] dc_s1, dc_next;
	logic [IDX_BITS-1:0] idx_s1;
	logic step_s1;
	logic [PRIO_BITS-1:0] top_prio;

	always_comb begin
		if (DELAY_BITS < TICK_IN_BITS && (ticks_q >> DELAY_BITS) != '0) ticks_sat = DELAY_MAX;
		else ticks_sat = DELAY_BITS'(ticks_q);
	end

	assign int_dec = (int_q != '0) ? int_q - 1'b1 : int_q;

	always_comb begin
		decide_need = 1'b0;
		case (op_q)
			OP_INT_EXIT: decide_need = running_q && int_dec == '0 && lock_q == '0;
			OP_UNLOCK: decide_need = running_q && int_q == '0 && lock_q == 8'd1;
			OP_SCHEDULE: decide_need = int_q == '0 && lock_q == '0;
			OP_START: decide_need = !running_q;
			default: decide_need = 1'b0;
		endcase
	end

	assign stat.decide_needed = decide_need;
	assign stat.sweep_needed = (op_q == OP_TICK) && running_q;
	assign stat.sweep_last = (idx_q == IDX_LAST);

	always_comb begin
		top_idx = '0;
		top_any = 1'b0;
		for (int i = 0; i < TASK_COUNT; i++) begin
			if (ready_q[i]) begin
				top_idx = IDX_BITS'(i);
				top_any = 1'b1;
			end
		end
	end
	assign top_prio = PRIO_BITS'(top_idx);

	assign dc_next = (dc_s1 != '0) ? dc_s1 - 1'b1 : dc_s1;

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q <= operation;
			prio_q <= IDX_BITS'(task_prio);
			ticks_q <= delay_ticks;
		end
		if (cmd.exec && op_q == OP_DELAY && ticks_q != '0) dcount_q[prio_q] <= ticks_sat;
		if (cmd.sweep_step) begin
			dc_s1 <= dcount_q[idx_q];
			idx_s1 <= idx_q;
		end
		if (step_s1 && blocked_q[idx_s1]) dcount_q[idx_s1] <= dc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
			blocked_q <= '0;
			susp_q <= '0;
			int_q <= '0;
			lock_q <= '0;
			running_q <= 1'b0;
			cur_q <= '0;
			tick_q <= '0;
			idx_q <= '0;
			step_s1 <= 1'b0;
			decide_q <= 1'b0;
			from_int_q <= 1'b0;
			sw_q <= 1'b0;
			none_q <= 1'b0;
		end else begin
			step_s1 <= cmd.sweep_step;
			if (cmd.exec) begin
				decide_q <= 1'b0;
				from_int_q <= 1'b0;
				sw_q <= 1'b0;
				none_q <= 1'b0;
				idx_q <= '0;
				case (op_q)
					OP_TICK: tick_q <= tick_q + 1'b1;
					OP_INT_ENTER: if (running_q && int_q != DEPTH_MAX) int_q <= int_q + 1'b1;
					OP_INT_EXIT: if (running_q) int_q <= int_dec;
					OP_LOCK: if (running_q && int_q == '0 && lock_q != DEPTH_MAX)
						lock_q <= lock_q + 1'b1;
					OP_UNLOCK: if (running_q && int_q == '0 && lock_q != '0)
						lock_q <= lock_q - 1'b1;
					OP_READY: ready_q[prio_q] <= 1'b1;
					OP_UNREADY: ready_q[prio_q] <= 1'b0;
					OP_DELAY: if (ticks_q != '0) begin
						ready_q[prio_q] <= 1'b0;
						blocked_q[prio_q] <= 1'b1;
					end
					OP_SUSPEND: begin
						susp_q[prio_q] <= 1'b1;
						ready_q[prio_q] <= 1'b0;
					end
					OP_RESUME: begin
						susp_q[prio_q] <= 1'b0;
						if (!blocked_q[prio_q]) ready_q[prio_q] <= 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.sweep_step) idx_q <= idx_q + 1'b1;
			if (step_s1 && blocked_q[idx_s1] && dc_next == '0) begin
				blocked_q[idx_s1] <= 1'b0;
				if (!susp_q[idx_s1]) ready_q[idx_s1] <= 1'b1;
			end
			if (cmd.decide) begin
				decide_q <= 1'b1;
				from_int_q <= (op_q == OP_INT_EXIT);
				none_q <= !top_any;
				sw_q <= (top_prio != cur_q);
				cur_q <= top_prio;
				if (op_q == OP_START) running_q <= 1'b1;
			end
		end
	end

	assign next_prio = cur_q;
	assign decided = decide_q;
	assign switch_request = sw_q;
	assign from_interrupt = from_int_q;
	assign int_depth_now = int_q;
	assign lock_depth_now = lock_q;
	assign running_now = running_q;
	assign none_ready = none_q;
endmodule

// ===== rtl/core/priority_bitmap_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// Fixed-priority task scheduler with ready, blocked and suspended bitmaps.
// Input channel (in_valid/in_ready) takes one word: operation, task_prio,
// delay_ticks. Output channel (out_valid/out_ready) returns one result word
// per input word, in order.
// Each word passes through capture, execute and present; a decision adds a
// decide step. A tick while running walks every delay counter, one task per
// cycle, before its result is presented.
// Throughput is one word at a time: the next input word is taken only after
// the result word has been taken, so a stalled receiver holds the result
// and blocks new input.
// Reset clears all bitmaps, nesting counts, running flag, current task and
// tick count; delay counters are loaded when a task is delayed.
// task_prio is taken modulo TASK_COUNT.
module priority_bitmap_task_scheduler_top import pbts_pkg::*; #(
	parameter int TASK_COUNT = 64,
	parameter int WORD_BITS = 32,
	parameter int DELAY_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_BITS-1:0]      operation,
	input  logic [PRIO_BITS-1:0]    task_prio,
	input  logic [TICK_IN_BITS-1:0] delay_ticks,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PRIO_BITS-1:0]    next_prio,
	output logic                    decided,
	output logic                    switch_request,
	output logic                    from_interrupt,
	output logic [DEPTH_BITS-1:0]   int_depth_now,
	output logic [DEPTH_BITS-1:0]   lock_depth_now,
	output logic                    running_now,
	output logic                    none_ready
);
	cmd_t cmd;
	stat_t stat;

	pbts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	pbts_dp #(.TASK_COUNT(TASK_COUNT), .WORD_BITS(WORD_BITS), .DELAY_BITS(DELAY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_take(in_valid && in_ready),
		.operation(operation), .task_prio(task_prio), .delay_ticks(delay_ticks),
		.cmd(cmd), .stat(stat), .next_prio(next_prio), .decided(decided),
		.switch_request(switch_request), .from_interrupt(from_interrupt),
		.int_depth_now(int_depth_now), .lock_depth_now(lock_depth_now),
		.running_now(running_now), .none_ready(none_ready)
	);
endmodule

// ===== test/tb_priority_bitmap_task_scheduler_top.sv =====
`timescale 1ns / 1ps
module tb_priority_bitmap_task_scheduler_top;
	import pbts_pkg::*;

	typedef struct packed {
		logic [3:0]  op;
		logic [5:0]  prio;
		logic [15:0] ticks;
	} word_t;

	typedef struct packed {
		logic [5:0] next_prio;
		logic       decided;
		logic       switch_request;
		logic       from_interrupt;
		logic [7:0] int_depth;
		logic [7:0] lock_depth;
		logic       running;
		logic       none_ready;
	} sched_result_t;

	localparam int IDLE_LIMIT = 5000;
	localparam int WAIT_MARK = 16'hFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] operation = '0;
	logic [5:0] task_prio = '0;
	logic [15:0] delay_ticks = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] next_prio;
	logic decided, switch_request, from_interrupt, running_now, none_ready;
	logic [7:0] int_depth_now, lock_depth_now;

	word_t pending_words[$];
	sched_result_t expected_results[$];

	logic [63:0] ready_bits, blocked_bits, suspended_bits;
	logic [15:0] delay_left[64];
	logic [7:0] nest_int, nest_lock;
	logic sched_running;
	logic [5:0] cur_prio;
	logic [31:0] tick_total;

	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int decisions_seen = 0;
	int idle_cycles = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;

	always #4 clk = ~clk;

	priority_bitmap_task_scheduler_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .task_prio(task_prio), .delay_ticks(delay_ticks),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_prio(next_prio), .decided(decided), .switch_request(switch_request),
		.from_interrupt(from_interrupt), .int_depth_now(int_depth_now),
		.lock_depth_now(lock_depth_now), .running_now(running_now),
		.none_ready(none_ready)
	);

	function automatic sched_result_t predict_schedule(word_t w);
		sched_result_t r;
		logic take, from_int;
		int top;
		take = 0;
		from_int = 0;
		top = -1;
		case (w.op)
			OP_TICK: begin
				tick_total++;
				if (sched_running) begin
					for (int p = 0; p < 64; p++) begin
						if (blocked_bits[p]) begin
							if (delay_left[p] != 0) delay_left[p]--;
							if (delay_left[p] == 0) begin
								blocked_bits[p] = 0;
								if (!suspended_bits[p]) ready_bits[p] = 1;
							end
						end
					end
				end
			end
			OP_INT_ENTER: if (sched_running && nest_int != DEPTH_MAX) nest_int++;
			OP_INT_EXIT: begin
				if (sched_running) begin
					if (nest_int != 0) nest_int--;
					if (nest_int == 0 && nest_lock == 0) begin
						take = 1;
						from_int = 1;
					end
				end
			end
			OP_LOCK: begin
				if (sched_running && nest_int == 0 && nest_lock != DEPTH_MAX) nest_lock++;
			end
			OP_UNLOCK: begin
				if (sched_running && nest_int == 0 && nest_lock != 0) begin
					nest_lock--;
					if (nest_lock == 0) take = 1;
				end
			end
			OP_SCHEDULE: if (nest_int == 0 && nest_lock == 0) take = 1;
			OP_START: begin
				if (!sched_running) begin
					take = 1;
					sched_running = 1;
				end
			end
			OP_READY: ready_bits[w.prio] = 1;
			OP_UNREADY: ready_bits[w.prio] = 0;
			OP_DELAY: begin
				if (w.ticks != 0) begin
					ready_bits[w.prio] = 0;
					blocked_bits[w.prio] = 1;
					delay_left[w.prio] = w.ticks;
				end
			end
			OP_SUSPEND: begin
				suspended_bits[w.prio] = 1;
				ready_bits[w.prio] = 0;
			end
			OP_RESUME: begin
				suspended_bits[w.prio] = 0;
				if (!blocked_bits[w.prio]) ready_bits[w.prio] = 1;
			end
			default: ;
		endcase
		r = '0;
		r.next_prio = cur_prio;
		if (take) begin
			for (int p = 63; p >= 0; p--) begin
				if (top < 0 && ready_bits[p]) top = p;
			end
			r.none_ready = (top < 0);
			r.next_prio = (top < 0) ? 6'd0 : 6'(top);
			r.switch_request = (r.next_prio != cur_prio);
			cur_prio = r.next_prio;
		end
		r.decided = take;
		r.from_interrupt = from_int;
		r.int_depth = nest_int;
		r.lock_depth = nest_lock;
		r.running = sched_running;
		return r;
	endfunction

	task automatic queue_word(logic [3:0] op, int prio, int ticks);
		word_t w;
		w.op = op;
		w.prio = 6'(prio);
		w.ticks = 16'(ticks);
		pending_words.push_back(w);
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_results.push_back(predict_schedule({operation, task_prio, delay_ticks}));
			words_sent++;
		end
		if (!in_valid || in_ready) begin
			if (pending_words.size() > 0 && pending_words[0].ticks == WAIT_MARK
					&& pending_words[0].op == 4'hF) begin
				in_valid <= 1'b0;
				if (expected_results.size() == 0 && !(in_valid && in_ready))
					void'(pending_words.pop_front());
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_words.size() > 0 && arst_n) begin
				word_t w;
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				operation <= w.op;
				task_prio <= w.prio;
				delay_ticks <= w.ticks;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sched_result_t got, want;
			got = {next_prio, decided, switch_request, from_interrupt,
				int_depth_now, lock_depth_now, running_now, none_ready};
			results_seen++;
			if (got.decided) decisions_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got != want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
		cycle_count <= cycle_count + 1;
		case ((results_seen / 64) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= cycle_count[2];
			default: out_ready <= ($urandom_range(0, 1) == 1);
		endcase
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int rest;
		ready_bits = '0;
		blocked_bits = '0;
		suspended_bits = '0;
		for (int p = 0; p < 64; p++) delay_left[p] = '0;
		nest_int = '0;
		nest_lock = '0;
		sched_running = 0;
		cur_prio = '0;
		tick_total = '0;

		// directed: before start, then start and nesting
		queue_word(OP_TICK, 0, 0);
		queue_word(OP_INT_ENTER, 5, 0);
		queue_word(OP_SCHEDULE, 0, 0);
		queue_word(OP_READY, 63, 0);
		queue_word(OP_READY, 0, 16'hFFFF);
		queue_word(OP_START, 0, 0);
		queue_word(OP_START, 0, 0);
		queue_word(OP_DELAY, 63, 2);
		queue_word(OP_DELAY, 5, 0);
		queue_word(OP_SCHEDULE, 0, 0);
		queue_word(OP_SUSPEND, 0, 0);
		queue_word(OP_SCHEDULE, 0, 0);
		queue_word(OP_TICK, 0, 0);
		queue_word(OP_TICK, 0, 0);
		queue_word(OP_LOCK, 0, 0);
		queue_word(OP_INT_ENTER, 0, 0);
		queue_word(OP_LOCK, 0, 0);
		queue_word(OP_INT_EXIT, 0, 0);
		queue_word(OP_UNLOCK, 0, 0);
		queue_word(OP_INT_EXIT, 0, 0);
		queue_word(OP_RESUME, 0, 0);
		queue_word(OP_UNREADY, 63, 0);
		queue_word(4'd12, 42, 16'h5555);
		queue_word(4'd15, 21, 16'hAAAA);
		queue_word(4'hF, 0, WAIT_MARK);

		rest = 210;
		while (rest > 0) begin
			int k;
			k = $urandom_range(0, 99);
			if (k < 15) queue_word(OP_TICK, $urandom, $urandom);
			else if (k < 25) queue_word(OP_READY, $urandom, $urandom);
			else if (k < 32) queue_word(OP_UNREADY, $urandom, $urandom);
			else if (k < 42) queue_word(OP_DELAY, $urandom,
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4));
			else if (k < 48) queue_word(OP_SUSPEND, $urandom, $urandom);
			else if (k < 55) queue_word(OP_RESUME, $urandom, $urandom);
			else if (k < 65) queue_word(OP_SCHEDULE, $urandom, $urandom);
			else if (k < 72) queue_word(OP_INT_ENTER, $urandom, $urandom);
			else if (k < 80) queue_word(OP_INT_EXIT, $urandom, $urandom);
			else if (k < 87) queue_word(OP_LOCK, $urandom, $urandom);
			else if (k < 95) queue_word(OP_UNLOCK, $urandom, $urandom);
			else if (k < 97) queue_word(OP_START, $urandom, $urandom);
			else queue_word(4'($urandom_range(12, 15)), $urandom, $urandom);
			rest--;
		end

		// saturate interrupt nesting, then step back down
		queue_word(4'hF, 0, WAIT_MARK);
		for (int i = 0; i < 257; i++) queue_word(OP_INT_ENTER, 0, 0);
		for (int i = 0; i < 3; i++) queue_word(OP_INT_EXIT, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_words.size() == 0);
		@(posedge clk);
		wait (!in_valid && expected_results.size() == 0);
		repeat (100) @(posedge clk);
		$display("Covered %0d words, %0d results, %0d scheduling decisions.",
			words_sent, results_seen, decisions_seen);
		$display("Interrupt nesting saturation, delays, suspend/resume and idle picks exercised.");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
